// ===== hw/rtl/ptq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types, codes and helpers of the periodic timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int IDX_W       = $clog2(NUM_TIMERS);
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int SLOT_W      = 4;

	localparam logic [63:0] TIME_NEVER = '1;

	typedef enum logic [2:0] {
		ACT_CREATE = 3'd0,
		ACT_UPDATE = 3'd1,
		ACT_DELETE = 3'd2,
		ACT_TICK   = 3'd3,
		ACT_CBDONE = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_FIRED   = 2'd1,
		KIND_REMOVED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_PENDING = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic [63:0] expiry;
		logic [31:0] period;
		logic [7:0]  pcount;
	} entry_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {33'd0, b};
		return s[64] ? TIME_NEVER : s[63:0];
	endfunction

endpackage

// ===== hw/rtl/ptq_if.sv =====
// ----------------------------------------------------------------------------
// ptq_req_if / ptq_rsp_if
// Valid/ready channels for requests and results of the timer queue.
// ----------------------------------------------------------------------------
interface ptq_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [3:0]  slot;
	logic [31:0] due_ms;
	logic [31:0] period_ms;
	logic        want_notice;

	modport source (output valid, action, slot, due_ms, period_ms, want_notice, input ready);
	modport sink   (input valid, action, slot, due_ms, period_ms, want_notice, output ready);
endinterface

interface ptq_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] timer_id;
	logic [1:0] status;
	logic       last;

	modport source (output valid, kind, timer_id, status, last, input ready);
	modport sink   (input valid, kind, timer_id, status, last, output ready);
endinterface

// ===== hw/rtl/ptq_table.sv =====
// ----------------------------------------------------------------------------
// ptq_table
// Per-timer entry store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ptq_table (
	input  logic                  clk,
	input  logic [ptq_pkg::IDX_W-1:0] rd_addr,
	output ptq_pkg::entry_t       rd_data,
	input  logic                  we,
	input  logic [ptq_pkg::IDX_W-1:0] wr_addr,
	input  ptq_pkg::entry_t       wr_data
);
	import ptq_pkg::*;

	entry_t mem [NUM_TIMERS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== hw/rtl/periodic_timer_queue.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_queue
// Table of software timers with a millisecond clock, firing in expiry order.
//
// channel  dir  payload
// req      in   action, slot, due_ms, period_ms, want_notice
// rsp      out  kind, timer_id, status, last
//
// Create, update, delete and callback done pass through S_EXEC, waiting there
// on output stalls; a callback done that also reports a removed timer adds S_NOTICE.
// A tick scans every entry for the earliest due timer, fires it through S_PICK,
// S_FIRE and S_FIRE2, and scans again until a scan finds nothing; after a
// sixteenth firing S_FLUSH replaces that final scan.
// The entry store's single read port makes each firing need a full scan.
// Reset clears the clock and the per-timer flags; no clearing pass.
// A stalled rsp holds the sequencer; req is taken only between items.
// ----------------------------------------------------------------------------
module periodic_timer_queue (
	input  logic clk,
	input  logic arst_n,
	ptq_req_if.sink   req,
	ptq_rsp_if.source rsp
);
	import ptq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SCAN, S_PICK, S_FIRE, S_FIRE2, S_FLUSH, S_NOTICE
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] timer_id;
		logic [1:0] status;
		logic       last;
	} res_t;

	state_t             state_q;
	logic [2:0]         act_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [31:0]        due_q;
	logic [31:0]        per_in_q;
	logic               notice_in_q;
	logic [63:0]        now_q;
	logic [NUM_TIMERS-1:0] in_use_q, destroyed_q, notice_q, done_q;

	logic [IDX_W:0]     scan_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               best_vld_q;
	logic [IDX_W-1:0]   best_q;
	logic [63:0]        best_exp_q;
	logic [CNT_W-1:0]   nfired_q;
	logic               hold_vld_q;
	logic [IDX_W-1:0]   hold_q;
	logic [63:0]        nxt_q;
	logic [31:0]        fper_q;
	logic [7:0]         fpc_q;

	res_t               res_q;
	logic               rsp_valid_q;

	logic [IDX_W-1:0]   rd_addr, wr_addr, cur_idx, free_idx;
	entry_t             rd_e, wr_e;
	logic               we, out_free, slot_ok, full, cand_ok;
	logic [63:0]        fire_exp;

	ptq_table u_table (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_e),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_data (wr_e)
	);

	assign cur_idx  = IDX_W'(slot_q);
	assign slot_ok  = (int'(slot_q) < NUM_TIMERS) && in_use_q[cur_idx];
	assign full     = &in_use_q;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid    = rsp_valid_q;
	assign rsp.kind     = res_q.kind;
	assign rsp.timer_id = res_q.timer_id;
	assign rsp.status   = res_q.status;
	assign rsp.last     = res_q.last;

	always_comb begin
		free_idx = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign cand_ok = rd_vld_s1 && in_use_q[rd_idx_s1] && !destroyed_q[rd_idx_s1]
		&& !done_q[rd_idx_s1] && (rd_e.expiry != TIME_NEVER) && (rd_e.expiry <= now_q);

	assign fire_exp = (fper_q == 32'd0) ? TIME_NEVER :
		(nxt_q < now_q) ? sat_add(now_q, fper_q) : nxt_q;

	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = IDX_W'(req.slot);
			S_SCAN:  rd_addr = scan_q[IDX_W-1:0];
			S_PICK:  rd_addr = best_q;
			default: rd_addr = cur_idx;
		endcase
	end

	always_comb begin
		we      = 1'b0;
		wr_addr = cur_idx;
		wr_e    = rd_e;
		if (state_q == S_EXEC && out_free) begin
			case (act_q)
				ACT_CREATE: begin
					we      = !full;
					wr_addr = free_idx;
					wr_e    = '{expiry: sat_add(now_q, due_q), period: per_in_q, pcount: 8'd0};
				end
				ACT_UPDATE: begin
					we        = slot_ok && (rd_e.expiry != TIME_NEVER);
					wr_e.expiry = sat_add(now_q, due_q);
					wr_e.period = per_in_q;
				end
				ACT_DELETE: begin
					we          = slot_ok;
					wr_e.expiry = TIME_NEVER;
				end
				ACT_CBDONE: begin
					we          = slot_ok && (rd_e.pcount != 8'd0);
					wr_e.pcount = rd_e.pcount - 8'd1;
				end
				default: we = 1'b0;
			endcase
		end else if (state_q == S_FIRE2) begin
			we      = 1'b1;
			wr_addr = best_q;
			wr_e    = '{expiry: fire_exp, period: fper_q, pcount: fpc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic emit;
		logic go_notice;
		res_t res_n;
		emit      = 1'b0;
		go_notice = 1'b0;
		res_n     = res_q;
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= '0;
			slot_q      <= '0;
			due_q       <= '0;
			per_in_q    <= '0;
			notice_in_q <= 1'b0;
			now_q       <= '0;
			in_use_q    <= '0;
			destroyed_q <= '0;
			notice_q    <= '0;
			done_q      <= '0;
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			best_vld_q  <= 1'b0;
			best_q      <= '0;
			best_exp_q  <= '0;
			hold_vld_q  <= 1'b0;
			hold_q      <= '0;
			nxt_q       <= '0;
			fper_q      <= '0;
			fpc_q       <= '0;
			nfired_q    <= '0;
			scan_q      <= '0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) && (int'(scan_q) < NUM_TIMERS);
			rd_idx_s1 <= scan_q[IDX_W-1:0];

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q       <= req.action;
						slot_q      <= req.slot;
						due_q       <= req.due_ms;
						per_in_q    <= req.period_ms;
						notice_in_q <= req.want_notice;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (act_q == ACT_TICK) begin
						if (now_q != TIME_NEVER) begin
							now_q <= now_q + 64'd1;
						end
						done_q     <= '0;
						nfired_q   <= '0;
						hold_vld_q <= 1'b0;
						best_vld_q <= 1'b0;
						scan_q     <= '0;
						state_q    <= S_SCAN;
					end else if (out_free) begin
						emit  = 1'b1;
						res_n = '{kind: KIND_ACK, timer_id: slot_q, status: ST_INVALID,
							last: 1'b1};
						case (act_q)
							ACT_CREATE: begin
								if (full) begin
									res_n = '{KIND_ACK, 4'd0, ST_FULL, 1'b1};
								end else begin
									in_use_q[free_idx]    <= 1'b1;
									destroyed_q[free_idx] <= 1'b0;
									notice_q[free_idx]    <= 1'b0;
									res_n = '{KIND_ACK, 4'(free_idx), ST_OK, 1'b1};
								end
							end
							ACT_UPDATE: begin
								if (slot_ok) begin
									res_n.status = ST_OK;
								end
							end
							ACT_DELETE: begin
								if (slot_ok) begin
									res_n.status = (notice_in_q && rd_e.pcount == 8'd0) ?
										ST_OK : ST_PENDING;
									if (rd_e.pcount == 8'd0) begin
										in_use_q[cur_idx]    <= 1'b0;
										destroyed_q[cur_idx] <= 1'b0;
										notice_q[cur_idx]    <= 1'b0;
									end else begin
										destroyed_q[cur_idx] <= 1'b1;
										notice_q[cur_idx]    <= notice_in_q;
									end
								end
							end
							ACT_CBDONE: begin
								if (slot_ok && rd_e.pcount != 8'd0) begin
									res_n.status = ST_OK;
									if (destroyed_q[cur_idx] && rd_e.pcount == 8'd1) begin
										in_use_q[cur_idx]    <= 1'b0;
										destroyed_q[cur_idx] <= 1'b0;
										notice_q[cur_idx]    <= 1'b0;
										if (notice_q[cur_idx]) begin
											res_n.last = 1'b0;
											go_notice  = 1'b1;
										end
									end
								end
							end
							default: res_n.timer_id = 4'd0;
						endcase
						res_q   <= res_n;
						state_q <= go_notice ? S_NOTICE : S_IDLE;
					end
				end
				S_NOTICE: begin
					if (out_free) begin
						emit    = 1'b1;
						res_q   <= '{KIND_REMOVED, 4'(slot_q), ST_OK, 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (int'(scan_q) < NUM_TIMERS) begin
						scan_q <= scan_q + 1'b1;
					end
					if (cand_ok && (!best_vld_q || rd_e.expiry < best_exp_q)) begin
						best_vld_q <= 1'b1;
						best_q     <= rd_idx_s1;
						best_exp_q <= rd_e.expiry;
					end
					if (int'(scan_q) >= NUM_TIMERS && !rd_vld_s1) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (out_free) begin
						if (best_vld_q) begin
							if (hold_vld_q) begin
								emit       = 1'b1;
								res_q      <= '{KIND_FIRED, 4'(hold_q), ST_OK, 1'b0};
								hold_vld_q <= 1'b0;
							end
							state_q <= S_FIRE;
						end else begin
							emit  = 1'b1;
							res_q <= hold_vld_q ? '{KIND_FIRED, 4'(hold_q), ST_OK, 1'b1} :
								'{KIND_ACK, 4'd0, ST_OK, 1'b1};
							hold_vld_q <= 1'b0;
							state_q    <= S_IDLE;
						end
					end
				end
				S_FIRE: begin
					nxt_q   <= sat_add(rd_e.expiry, rd_e.period);
					fper_q  <= rd_e.period;
					fpc_q   <= (rd_e.pcount == 8'hFF) ? rd_e.pcount : rd_e.pcount + 8'd1;
					state_q <= S_FIRE2;
				end
				S_FIRE2: begin
					done_q[best_q] <= 1'b1;
					hold_q         <= best_q;
					hold_vld_q     <= 1'b1;
					nfired_q       <= nfired_q + 1'b1;
					best_vld_q     <= 1'b0;
					scan_q         <= '0;
					state_q <= (int'(nfired_q) == MAX_RESULTS - 1) ? S_FLUSH : S_SCAN;
				end
				S_FLUSH: begin
					if (out_free) begin
						emit       = 1'b1;
						res_q      <= '{KIND_FIRED, 4'(hold_q), ST_OK, 1'b1};
						hold_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_now_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		now_q >= $past(now_q)) else $error("clock moved backward");

	a_fire_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE |-> best_vld_q && !done_q[best_q])
		else $error("firing without an eligible timer");

	a_fire_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(nfired_q) <= MAX_RESULTS) else $error("too many firings in one tick");

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !hold_vld_q) else $error("held result lost");

	a_fired_marked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE2 |=> done_q[hold_q] && hold_vld_q)
		else $error("fired timer not marked");
endmodule
